[rtl/shelf_atlas_packer_assert.svh]
// Assertion macros shared by the shelf atlas packer RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef SHELF_ATLAS_PACKER_ASSERT_SVH
`define SHELF_ATLAS_PACKER_ASSERT_SVH

// Check a property on every rising clock edge, skipped while reset is low.
`define SAP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("shelf atlas packer check failed");

// Check a property that must also hold during reset.
`define SAP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("shelf atlas packer check failed");

`endif

[rtl/sap_pkg.sv]
// Types, constants and helper functions of the shelf atlas packer.
// No dependencies; sap_front, sap_queue, sap_back and the top level import this package.
package sap_pkg;

  localparam logic [15:0] EXT_SAT     = 16'd32768;
  localparam logic [12:0] ITEM_SAT    = 13'd4096;
  localparam logic [14:0] SIDE_RESET  = 15'd1024;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Emission phase of the back end for one queued bundle.
  typedef enum logic [1:0] {
    PH_OPEN,
    PH_PLACE,
    PH_CLOSE
  } phase_e;

  // Raw extents and item count of one closed atlas.
  typedef struct packed {
    logic [15:0] ext_w;
    logic [15:0] ext_h;
    logic [12:0] items;
  } atlas_stat_t;

  // Everything one rectangle produces, classified by the front end.
  typedef struct packed {
    logic        rep1_v;
    logic [15:0] rep1_atlas;
    atlas_stat_t rep1_stat;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [15:0] place_atlas;
    logic        rep2_v;
    atlas_stat_t rep2_stat;
  } bundle_t;

  // One result transaction.
  typedef struct packed {
    logic        kind;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [15:0] atlas_number;
    logic [15:0] atlas_width;
    logic [15:0] atlas_height;
    logic [12:0] items_in_atlas;
    logic        worth_building;
    logic        run_end;
  } result_t;

  // Smallest power of two not below v, at least 1 (v never exceeds 32768).
  function automatic logic [15:0] round_pow2(input logic [15:0] v);
    logic [15:0] m;
    if (v <= 16'd1) begin
      return 16'd1;
    end
    m = v - 16'd1;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m + 16'd1;
  endfunction

  function automatic result_t make_report(input logic [15:0] atlas, input atlas_stat_t st,
                                          input logic last);
    result_t r;
    r.kind           = 1'b1;
    r.pos_x          = '0;
    r.pos_y          = '0;
    r.atlas_number   = atlas;
    r.atlas_width    = round_pow2(st.ext_w);
    r.atlas_height   = round_pow2(st.ext_h);
    r.items_in_atlas = st.items;
    r.worth_building = (st.items > 13'd1);
    r.run_end        = last;
    return r;
  endfunction

  function automatic result_t make_place(input bundle_t b);
    result_t r;
    r.kind           = 1'b0;
    r.pos_x          = b.pos_x;
    r.pos_y          = b.pos_y;
    r.atlas_number   = b.place_atlas;
    r.atlas_width    = '0;
    r.atlas_height   = '0;
    r.items_in_atlas = '0;
    r.worth_building = 1'b0;
    r.run_end        = !b.rep2_v;
    return r;
  endfunction

endpackage

[rtl/sap_if.sv]
// Channel interfaces of the shelf atlas packer: rectangles, configuration, results.
// Depends on nothing; each carries valid, ready and its payload.
interface sap_rect_if;
  logic        valid;
  logic        ready;
  logic [14:0] rect_width;
  logic [14:0] rect_height;
  logic        list_end;
  modport source (output valid, rect_width, rect_height, list_end, input ready);
  modport sink (input valid, rect_width, rect_height, list_end, output ready);
endinterface

interface sap_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] atlas_side;
  modport source (output valid, atlas_side, input ready);
  modport sink (input valid, atlas_side, output ready);
endinterface

interface sap_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [14:0] pos_x;
  logic [14:0] pos_y;
  logic [15:0] atlas_number;
  logic [15:0] atlas_width;
  logic [15:0] atlas_height;
  logic [12:0] items_in_atlas;
  logic        worth_building;
  logic        run_end;
  modport source (output valid, kind, pos_x, pos_y, atlas_number, atlas_width, atlas_height,
                  items_in_atlas, worth_building, run_end, input ready);
  modport sink (input valid, kind, pos_x, pos_y, atlas_number, atlas_width, atlas_height,
                items_in_atlas, worth_building, run_end, output ready);
endinterface

[rtl/sap_front.sv]
// Front end: side register, packing state and per-rectangle classification.
// Depends on sap_pkg and the channel interfaces in sap_if.sv.
module sap_front
  import sap_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16384
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sap_rect_if.sink     rect_i,
  sap_cfg_if.sink      cfg_i,
  input  logic         full_i,
  output logic         push_o,
  output bundle_t      push_data_o
);

  localparam logic [15:0] MaxSide = 16'(MAX_SIDE);

  logic [14:0] atlas_side_q;
  logic [15:0] cursor_x_q, cursor_x_d;
  logic [15:0] shelf_top_q, shelf_top_d;
  logic [15:0] shelf_h_q, shelf_h_d;
  logic [15:0] ext_w_q, ext_w_d;
  logic [15:0] ext_h_q, ext_h_d;
  logic [15:0] atlas_q, atlas_d;
  logic [12:0] items_q, items_d;

  logic [15:0] side;
  logic [16:0] row_end, stack_sum, col_end, right_sum, bottom;
  logic        new_row, overflow, rep1_v;
  logic [15:0] cx1, st1, sh1, cx2, st2, sh2, ew2, eh2, sh3, right, ew3, eh3, atlas1;
  logic [12:0] ic2, ic3;

  assign cfg_i.ready  = 1'b1;
  assign rect_i.ready = !full_i;
  assign push_o       = rect_i.valid && !full_i;

  always_comb begin
    side = ({1'b0, atlas_side_q} < MaxSide) ? {1'b0, atlas_side_q} : MaxSide;

    // Start a new shelf when the row would pass the right edge.
    row_end   = {1'b0, cursor_x_q} + 17'(rect_i.rect_width);
    new_row   = row_end > {1'b0, side};
    stack_sum = {1'b0, shelf_top_q} + {1'b0, shelf_h_q};
    cx1 = new_row ? 16'd0 : cursor_x_q;
    st1 = new_row ? (stack_sum[16] ? 16'hFFFF : stack_sum[15:0]) : shelf_top_q;
    sh1 = new_row ? 16'd0 : shelf_h_q;

    // Close the atlas when the shelf would pass the bottom edge.
    col_end  = {1'b0, st1} + 17'(rect_i.rect_height);
    overflow = col_end > {1'b0, side};
    rep1_v   = overflow && (items_q != 13'd0);
    atlas1   = rep1_v ? atlas_q + 16'd1 : atlas_q;
    cx2 = overflow ? 16'd0 : cx1;
    st2 = overflow ? 16'd0 : st1;
    sh2 = overflow ? 16'd0 : sh1;
    ew2 = overflow ? 16'd0 : ext_w_q;
    eh2 = overflow ? 16'd0 : ext_h_q;
    ic2 = overflow ? 13'd0 : items_q;

    // Place and grow the extents.
    sh3       = ({1'b0, rect_i.rect_height} > sh2) ? {1'b0, rect_i.rect_height} : sh2;
    right_sum = {1'b0, cx2} + 17'(rect_i.rect_width);
    right     = right_sum[16] ? 16'hFFFF : right_sum[15:0];
    bottom    = {1'b0, st2} + 17'(rect_i.rect_height);
    ew3 = (right > ew2) ? ((right > EXT_SAT) ? EXT_SAT : right) : ew2;
    eh3 = (bottom > {1'b0, eh2}) ?
          ((bottom > {1'b0, EXT_SAT}) ? EXT_SAT : bottom[15:0]) : eh2;
    ic3 = (ic2 < ITEM_SAT) ? ic2 + 13'd1 : ic2;

    push_data_o.rep1_v          = rep1_v;
    push_data_o.rep1_atlas      = atlas_q;
    push_data_o.rep1_stat.ext_w = ext_w_q;
    push_data_o.rep1_stat.ext_h = ext_h_q;
    push_data_o.rep1_stat.items = items_q;
    push_data_o.pos_x           = cx2[14:0];
    push_data_o.pos_y           = st2[14:0];
    push_data_o.place_atlas     = atlas1;
    push_data_o.rep2_v          = rect_i.list_end;
    push_data_o.rep2_stat.ext_w = ew3;
    push_data_o.rep2_stat.ext_h = eh3;
    push_data_o.rep2_stat.items = ic3;

    // Drop all packing state after the final rectangle of a list.
    if (rect_i.list_end) begin
      cursor_x_d  = '0;
      shelf_top_d = '0;
      shelf_h_d   = '0;
      ext_w_d     = '0;
      ext_h_d     = '0;
      items_d     = '0;
      atlas_d     = '0;
    end else begin
      cursor_x_d  = right;
      shelf_top_d = st2;
      shelf_h_d   = sh3;
      ext_w_d     = ew3;
      ext_h_d     = eh3;
      items_d     = ic3;
      atlas_d     = atlas1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_side_q <= SIDE_RESET;
      cursor_x_q   <= '0;
      shelf_top_q  <= '0;
      shelf_h_q    <= '0;
      ext_w_q      <= '0;
      ext_h_q      <= '0;
      items_q      <= '0;
      atlas_q      <= '0;
    end else begin
      if (cfg_i.valid) begin
        atlas_side_q <= cfg_i.atlas_side;
      end
      if (push_o) begin
        cursor_x_q  <= cursor_x_d;
        shelf_top_q <= shelf_top_d;
        shelf_h_q   <= shelf_h_d;
        ext_w_q     <= ext_w_d;
        ext_h_q     <= ext_h_d;
        items_q     <= items_d;
        atlas_q     <= atlas_d;
      end
    end
  end

endmodule

[rtl/sap_queue.sv]
// Short bundle queue between the front and back ends of the packer.
// Depends on sap_pkg and the assertion macros header.
`include "shelf_atlas_packer_assert.svh"

module sap_queue
  import sap_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    head_valid_o,
  output bundle_t head_o
);

  localparam logic [QPTR_W:0] Depth = (QPTR_W + 1)'(QUEUE_DEPTH);

  bundle_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o       = (count_q == Depth);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `SAP_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= Depth)
  `SAP_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> head_valid_o)
  `SAP_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o)

endmodule

[rtl/sap_back.sv]
// Back end: walks each queued bundle and emits its results through an output register.
// Depends on sap_pkg, sap_if.sv and the assertion macros header.
`include "shelf_atlas_packer_assert.svh"

module sap_back
  import sap_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  bundle_t       head_i,
  output logic          pop_o,
  sap_result_if.source  result_o
);

  phase_e  phase_q, phase_d, cur_phase;
  logic    valid_q;
  result_t res_q, res_d;
  logic    load, fire, bundle_done;

  // Skip the overflow report when the bundle has none.
  assign cur_phase = (phase_q == PH_OPEN && !head_i.rep1_v) ? PH_PLACE : phase_q;
  assign load      = !valid_q || result_o.ready;
  assign fire      = load && head_valid_i;

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (fire) begin
      unique case (cur_phase)
        PH_OPEN:  phase_d = PH_PLACE;
        PH_PLACE: phase_d = head_i.rep2_v ? PH_CLOSE : PH_OPEN;
        PH_CLOSE: phase_d = PH_OPEN;
        default:  phase_d = PH_OPEN;
      endcase
    end
  end

  // Result of the current phase.
  always_comb begin
    unique case (cur_phase)
      PH_OPEN: begin
        res_d       = make_report(head_i.rep1_atlas, head_i.rep1_stat, 1'b0);
        bundle_done = 1'b0;
      end
      PH_PLACE: begin
        res_d       = make_place(head_i);
        bundle_done = !head_i.rep2_v;
      end
      PH_CLOSE: begin
        res_d       = make_report(head_i.place_atlas, head_i.rep2_stat, 1'b1);
        bundle_done = 1'b1;
      end
      default: begin
        res_d       = '0;
        bundle_done = 1'b1;
      end
    endcase
  end

  assign pop_o = fire && bundle_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPEN;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = valid_q;
  assign result_o.kind           = res_q.kind;
  assign result_o.pos_x          = res_q.pos_x;
  assign result_o.pos_y          = res_q.pos_y;
  assign result_o.atlas_number   = res_q.atlas_number;
  assign result_o.atlas_width    = res_q.atlas_width;
  assign result_o.atlas_height   = res_q.atlas_height;
  assign result_o.items_in_atlas = res_q.items_in_atlas;
  assign result_o.worth_building = res_q.worth_building;
  assign result_o.run_end        = res_q.run_end;

  `SAP_ASSERT(a_pop_marks_end, clk_i, rst_ni, pop_o |=> (valid_q && res_q.run_end))
  `SAP_ASSERT(a_phase_idle_empty, clk_i, rst_ni, !head_valid_i |-> !pop_o)
  `SAP_ASSERT(a_close_has_end, clk_i, rst_ni,
              (fire && cur_phase == PH_CLOSE) |-> pop_o)

endmodule

[rtl/shelf_atlas_packer.sv]
// Top level of the shelf atlas packer: front end, bundle queue and back end.
// Depends on sap_pkg, sap_if.sv, sap_front, sap_queue and sap_back.
//
//   channel   direction  payload                                          accepted when
//   rect_i    in         rect_width, rect_height, list_end                valid && ready
//   cfg_i     in         atlas_side                                       valid && ready
//   result_o  out        kind, pos_x, pos_y, atlas_number, atlas_width,   valid && ready
//                        atlas_height, items_in_atlas, worth_building,
//                        run_end
//
// A rectangle is taken every cycle while the four-entry bundle queue has room; it leaves
// one to three result transactions, which the back end emits through its output register at
// one per cycle while result_o is ready, so the sustained rate is one rectangle per cycle
// for plain placements and lower when overflow and flush reports follow.
// Reset clears all packing state, empties the queue and loads an atlas side of 1024.
// Stalls on result_o back up into the queue only; the front end keeps accepting until full.
module shelf_atlas_packer
  import sap_pkg::*;
#(
  parameter int unsigned MAX_SIDE = 16384
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sap_rect_if.sink      rect_i,
  sap_cfg_if.sink       cfg_i,
  sap_result_if.source  result_o
);

  // Front to queue.
  logic    push, full;
  bundle_t push_data;

  // Queue to back end.
  logic    pop, head_valid;
  bundle_t head;

  // Classify each rectangle and advance the packing state at once.
  sap_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rect_i      (rect_i),
    .cfg_i       (cfg_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold classified bundles so a stalled result side does not stop the front end.
  sap_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Expand each bundle into its report, placement and flush transactions.
  sap_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule

[test/sap_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard of the shelf atlas packer testbench: its own next-fit shelf predictor and the
// queue of expected result transactions. Depends on sap_pkg for result_t and saturation limits.
package sap_tb_pkg;
  import sap_pkg::*;

  localparam int unsigned PACKER_MAX_SIDE = 16384;
  localparam logic KIND_PLACE  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  class packing_scoreboard;
    logic [14:0] side_reg;
    logic [15:0] cursor_x;
    logic [15:0] shelf_top;
    logic [15:0] shelf_height;
    logic [15:0] extent_w;
    logic [15:0] extent_h;
    logic [15:0] atlas_no;
    logic [12:0] item_count;
    result_t     expected_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      side_reg   = SIDE_RESET;
      atlas_no   = '0;
      clear_atlas();
    endfunction

    function void clear_atlas();
      cursor_x     = '0;
      shelf_top    = '0;
      shelf_height = '0;
      extent_w     = '0;
      extent_h     = '0;
      item_count   = '0;
    endfunction

    function void set_side(logic [14:0] v);
      side_reg = v;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Append one expected result at the tail of the queue.
    function void queue_expected(result_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    static function logic [15:0] pow2_ceiling(logic [15:0] v);
      int unsigned p;
      p = 1;
      while (p < v && p < EXT_SAT) p = p << 1;
      return 16'(p);
    endfunction

    function result_t atlas_report();
      result_t r;
      r                = '0;
      r.kind           = KIND_REPORT;
      r.atlas_number   = atlas_no;
      r.atlas_width    = pow2_ceiling(extent_w);
      r.atlas_height   = pow2_ceiling(extent_h);
      r.items_in_atlas = item_count;
      r.worth_building = (item_count > 13'd1);
      return r;
    endfunction

    // Place one accepted rectangle and queue the one to three results it causes.
    function void note_rect(logic [14:0] w, logic [14:0] h, logic last);
      int unsigned side, sum, right, bottom;
      result_t     place;
      side = (side_reg < PACKER_MAX_SIDE) ? side_reg : PACKER_MAX_SIDE;
      sum  = 32'(cursor_x) + 32'(w);
      if (sum > side) begin
        cursor_x     = '0;
        sum          = 32'(shelf_top) + 32'(shelf_height);
        shelf_top    = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
        shelf_height = '0;
      end
      if (32'(shelf_top) + 32'(h) > side) begin
        if (item_count != '0) begin
          queue_expected(atlas_report());
          atlas_no = atlas_no + 16'd1;
        end
        clear_atlas();
      end
      if (h > shelf_height) shelf_height = 16'(h);

      place              = '0;
      place.kind         = KIND_PLACE;
      place.pos_x        = cursor_x[14:0];
      place.pos_y        = shelf_top[14:0];
      place.atlas_number = atlas_no;
      queue_expected(place);

      right    = 32'(cursor_x) + 32'(w);
      if (right > 32'hFFFF) right = 32'hFFFF;
      cursor_x = right[15:0];
      bottom   = 32'(shelf_top) + 32'(h);
      if (right > extent_w) extent_w = (right > EXT_SAT) ? EXT_SAT : right[15:0];
      if (bottom > extent_h) extent_h = (bottom > EXT_SAT) ? EXT_SAT : bottom[15:0];
      if (item_count < ITEM_SAT) item_count = item_count + 13'd1;

      if (last) begin
        queue_expected(atlas_report());
        atlas_no = '0;
        clear_atlas();
      end

      expected_results[expected_results.size() - 1].run_end = 1'b1;
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d atlas_number %0d", got.kind, got.atlas_number);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare("kind", 16'(want.kind), 16'(got.kind));
      compare("pos_x", 16'(want.pos_x), 16'(got.pos_x));
      compare("pos_y", 16'(want.pos_y), 16'(got.pos_y));
      compare("atlas_number", want.atlas_number, got.atlas_number);
      compare("atlas_width", want.atlas_width, got.atlas_width);
      compare("atlas_height", want.atlas_height, got.atlas_height);
      compare("items_in_atlas", 16'(want.items_in_atlas), 16'(got.items_in_atlas));
      compare("worth_building", 16'(want.worth_building), 16'(got.worth_building));
      compare("run_end", 16'(want.run_end), 16'(got.run_end));
    endfunction
  endclass

endpackage

[test/tb.sv]
`timescale 1ns / 100ps
// Top of the shelf atlas packer testbench: clock, reset, rectangle and side drivers, result
// monitor and watchdog. Depends on sap_pkg, the RTL channel interfaces and sap_tb_pkg.
module tb;
  import sap_pkg::*;
  import sap_tb_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles without any transaction
  localparam int unsigned DRAIN_CYCLES = 12;    // settle time before a side write
  localparam int unsigned HOLD_CYCLES  = 90;    // long receiver hold-off
  localparam int unsigned PHASE_ITEMS  = 24;

  logic clk = 1'b0;
  logic rst_n;

  sap_rect_if   rect_if ();
  sap_cfg_if    cfg_if ();
  sap_result_if result_if ();

  packing_scoreboard sb;

  logic        offering;           // shadow of rect_if.valid as this process last drove it
  int unsigned burst_left;         // rectangles left in the current sender burst
  bit          steady;             // suppress sender gaps
  int unsigned hold_requests;      // raised by the stimulus, served by the receiver
  int unsigned holds_served = 0;
  int unsigned hold_count = 0;
  logic [9:0]  rx_cycle = '0;
  int unsigned idle_cycles = 0;

  shelf_atlas_packer #(.MAX_SIDE(PACKER_MAX_SIDE)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .rect_i  (rect_if),
    .cfg_i   (cfg_if),
    .result_o(result_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every accepted result transaction, then pick the next ready.
  // The stall pattern rotates with rx_cycle through always ready, coin flip, mostly
  // stalled and on / off from rx_cycle[2]; a hold request overrides it.
  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (result_if.valid && result_if.ready) begin
        got.kind           = result_if.kind;
        got.pos_x          = result_if.pos_x;
        got.pos_y          = result_if.pos_y;
        got.atlas_number   = result_if.atlas_number;
        got.atlas_width    = result_if.atlas_width;
        got.atlas_height   = result_if.atlas_height;
        got.items_in_atlas = result_if.items_in_atlas;
        got.worth_building = result_if.worth_building;
        got.run_end        = result_if.run_end;
        sb.check_result(got);
      end
      rx_cycle = rx_cycle + 10'd1;
      if (hold_count != 0) begin
        hold_count--;
        result_if.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_count = HOLD_CYCLES;
        result_if.ready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0: result_if.ready <= 1'b1;
          2'd1: result_if.ready <= 1'($urandom_range(0, 1));
          2'd2: result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= rx_cycle[2];
        endcase
      end
    end else begin
      result_if.ready <= 1'b0;
    end
  end

  // Watchdog: end the run when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rect_if.valid && rect_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (result_if.valid && result_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Offer one rectangle, hold it until accepted, then note it for prediction.
  // Between bursts, unless steady is set, drop valid and idle before the next burst.
  task automatic send_rect(input logic [14:0] w, input logic [14:0] h, input logic last);
    rect_if.valid       <= 1'b1;
    rect_if.rect_width  <= w;
    rect_if.rect_height <= h;
    rect_if.list_end    <= last;
    offering = 1'b1;
    @(posedge clk);
    while (!rect_if.ready) @(posedge clk);
    sb.note_rect(w, h, last);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady) begin
      rect_if.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic stop_offering();
    if (offering) begin
      rect_if.valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Wait until every expected result is in, let the pipeline settle, then write the side.
  task automatic write_side(input logic [14:0] side);
    stop_offering();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.atlas_side <= side;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_side(side);
  endtask

  // Mostly small sizes relative to the side so shelves fill up; some up to the side,
  // some anywhere in range, and a few corner values.
  function automatic logic [14:0] pick_dim(input int unsigned cap);
    int unsigned roll;
    int unsigned v;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      v = $urandom_range(0, cap / 4 + 1);
    end else if (roll < 85) begin
      v = $urandom_range(0, cap + 1);
    end else if (roll < 95) begin
      v = $urandom_range(0, 16384);
    end else begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 16383;
        2: v = 16384;
        default: v = cap;
      endcase
    end
    if (v > 16384) v = 16384;
    return v[14:0];
  endfunction

  // Send lists of 1..12 rectangles that end in list_end; about one list in seven is noise
  // with list_end set at random, so atlases also carry over from one list to the next.
  task automatic run_lists(input int unsigned count, input logic [14:0] side);
    int unsigned cap;
    int unsigned sent;
    int unsigned len;
    bit          noisy;
    cap  = (side < PACKER_MAX_SIDE) ? side : PACKER_MAX_SIDE;
    sent = 0;
    while (sent < count) begin
      len   = $urandom_range(1, 12);
      noisy = ($urandom_range(0, 6) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        send_rect(pick_dim(cap), pick_dim(cap),
                  noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    offering      = 1'b0;
    burst_left    = 0;
    steady        = 1'b0;
    hold_requests = 0;
    rect_if.valid       = 1'b0;
    rect_if.rect_width  = '0;
    rect_if.rect_height = '0;
    rect_if.list_end    = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.atlas_side   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset side of 1024.
    send_rect(15'd0, 15'd0, 1'b0);          // empty rectangle at the origin
    send_rect(15'd1024, 15'd1, 1'b0);       // exactly the row width
    send_rect(15'd1, 15'd1, 1'b0);          // row overflow opens a shelf
    send_rect(15'd1023, 15'd1023, 1'b0);    // fills to the bottom edge exactly
    send_rect(15'd1, 15'd1, 1'b0);          // shelf and atlas overflow: report, new atlas
    send_rect(15'd16384, 15'd16384, 1'b1);  // oversized, overflow report, placement, flush
    send_rect(15'd2000, 15'd5, 1'b0);       // fresh list, wider than the side
    send_rect(15'd7, 15'd3000, 1'b0);       // closes a one-item atlas
    send_rect(15'd10, 15'd10, 1'b1);        // flush of a two-item atlas
    send_rect(15'd5, 15'd1025, 1'b0);       // too tall in an empty atlas: no report
    send_rect(15'd5, 15'd5, 1'b1);
    send_rect(15'd0, 15'd1024, 1'b0);
    send_rect(15'd16383, 15'd0, 1'b1);

    // Side of zero: every rectangle that is not empty overflows.
    write_side(15'd0);
    send_rect(15'd0, 15'd0, 1'b0);
    send_rect(15'd1, 15'd0, 1'b0);
    send_rect(15'd0, 15'd1, 1'b0);
    send_rect(15'd0, 15'd0, 1'b1);

    // Random lists over a spread of sides, the extremes among them.
    write_side(15'd1);
    run_lists(PHASE_ITEMS, 15'd1);
    write_side(15'd16384);
    run_lists(PHASE_ITEMS, 15'd16384);

    // Hold off the receiver while the sender keeps offering back to back, so the
    // bundle queue fills and the rectangle channel stalls.
    write_side(15'd32767);
    steady = 1'b1;
    hold_requests++;
    run_lists(PHASE_ITEMS, 15'd32767);
    steady = 1'b0;

    write_side(15'd64);
    run_lists(PHASE_ITEMS, 15'd64);
    begin
      logic [14:0] side;
      side = 15'($urandom_range(2, 16384));
      write_side(side);
      run_lists(PHASE_ITEMS, side);
    end
    write_side(15'd300);
    run_lists(PHASE_ITEMS, 15'd300);
    write_side(SIDE_RESET);
    run_lists(PHASE_ITEMS, SIDE_RESET);

    // Drain and give the block time to show any stray result.
    stop_offering();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
